/* sv/ntt_butterfly_barrett_core_defines.svh */
// Assertion macros shared by the NTT butterfly RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef NTT_BUTTERFLY_BARRETT_CORE_DEFINES_SVH
`define NTT_BUTTERFLY_BARRETT_CORE_DEFINES_SVH

// same-cycle implication
`define NBB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nbb assertion failed");

// next-cycle implication
`define NBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nbb assertion failed");

`endif

/* sv/nbb_pkg.sv */
// Package for the NTT butterfly: fixed widths, register codes, pipeline
// stage numbers and the multiplier control struct. No dependencies.
package nbb_pkg;

   localparam int Q_BITS        = 30;
   localparam int W_BITS        = 5;
   localparam int U_BITS        = 31;
   localparam int DP_BITS       = 64;
   localparam int HALF_BITS     = 32;
   localparam int DIFF_BITS     = 32;
   localparam int SH2_BITS      = 6;
   localparam int BARRETT_OFS   = 2;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_IDX_LSB   = 2;

   typedef logic [CSR_ADDR_BITS-CSR_IDX_LSB-1:0] nbb_reg_index_type;

   localparam nbb_reg_index_type REG_MODULUS        = 2'd0;
   localparam nbb_reg_index_type REG_MODULUS_BITS   = 2'd1;
   localparam nbb_reg_index_type REG_BARRETT_FACTOR = 2'd2;

   localparam logic [Q_BITS-1:0] MODULUS_RESET        = 30'd12289;
   localparam logic [W_BITS-1:0] MODULUS_BITS_RESET   = 5'd14;
   localparam logic [U_BITS-1:0] BARRETT_FACTOR_RESET = 31'd21843;

   // pipeline stage numbers
   localparam int ST_SUM  = 1;
   localparam int ST_TW   = 2;
   localparam int ST_SH1  = 3;
   localparam int ST_X2P  = 4;
   localparam int ST_X2   = 5;
   localparam int ST_S    = 6;
   localparam int ST_SQP  = 7;
   localparam int ST_SQ   = 8;
   localparam int ST_C    = 9;
   localparam int ST_OUT  = 10;
   localparam int STAGES  = 10;

   typedef struct packed {
      logic part_en;
      logic sum_en;
   } nbb_mul_ctl_type;

endpackage

/* sv/nbb_req_if.sv */
// Input channel of the NTT butterfly: valid/ready plus one butterfly word.
// No dependencies.
interface nbb_req_if #(
   parameter int VALUE_BITS = 30
) ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] upper_value;
   logic [VALUE_BITS-1:0] lower_value;
   logic [VALUE_BITS-1:0] twiddle;

   modport source (output valid, upper_value, lower_value, twiddle, input ready);
   modport sink   (input valid, upper_value, lower_value, twiddle, output ready);
endinterface

/* sv/nbb_rsp_if.sv */
// Result channel of the NTT butterfly: valid/ready plus one result word.
// No dependencies.
interface nbb_rsp_if #(
   parameter int VALUE_BITS = 30
) ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] sum_out;
   logic [VALUE_BITS-1:0] product_out;

   modport source (output valid, sum_out, product_out, input ready);
   modport sink   (input valid, sum_out, product_out, output ready);
endinterface

/* sv/ntt_butterfly_barrett_core.sv */
// Gentleman-Sande NTT butterfly with Barrett reduction of the twiddle product.
// Depends on nbb_pkg, nbb_req_if, nbb_rsp_if, nbb_wrap_mul and the defines header.
//
// One butterfly word is accepted per clock while input is not refused, and its
// result leaves through a ten-stage pipeline: modular add/subtract, twiddle
// multiply, first Barrett shift, two-stage x*u multiply, second shift, two-stage
// s*q multiply, subtract, final conditional correction. Each stage holds its word
// when the next stage is stalled too, so bubbles close up under back-pressure and
// input is refused only when all ten stages hold words. Modulus, modulus_bits
// and barrett_factor sit on the APB port at byte addresses 0, 4 and 8 and are
// read live by the datapath, so write them only while no word is in flight.
`include "ntt_butterfly_barrett_core_defines.svh"

module ntt_butterfly_barrett_core #(
   parameter int VALUE_BITS = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   nbb_req_if.sink                             req_bus,
   nbb_rsp_if.source                           rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nbb_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [nbb_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [nbb_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import nbb_pkg::*;

   localparam int SUM_BITS  = Q_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + VALUE_BITS + 1;

   // ---------------- configuration registers ----------------
   logic [Q_BITS-1:0]  modulus_ff;
   logic [W_BITS-1:0]  modulus_bits_ff;
   logic [U_BITS-1:0]  barrett_factor_ff;
   nbb_reg_index_type  reg_idx;
   logic               csr_wr;

   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:CSR_IDX_LSB];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff        <= MODULUS_RESET;
         modulus_bits_ff   <= MODULUS_BITS_RESET;
         barrett_factor_ff <= BARRETT_FACTOR_RESET;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_MODULUS:        modulus_ff        <= csr_pwdata[Q_BITS-1:0];
            REG_MODULUS_BITS:   modulus_bits_ff   <= csr_pwdata[W_BITS-1:0];
            REG_BARRETT_FACTOR: barrett_factor_ff <= csr_pwdata[U_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MODULUS:        csr_prdata = CSR_DATA_BITS'(modulus_ff);
         REG_MODULUS_BITS:   csr_prdata = CSR_DATA_BITS'(modulus_bits_ff);
         REG_BARRETT_FACTOR: csr_prdata = CSR_DATA_BITS'(barrett_factor_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic [STAGES:1]   valid_ff;
   logic [STAGES+1:1] stage_en;
   logic              in_acc;
   logic              out_acc;

   always_comb begin
      stage_en[STAGES+1] = rsp_bus.ready;
      for (int k = STAGES; k >= 1; k--) begin
         stage_en[k] = ~valid_ff[k] | stage_en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[1]) begin
            valid_ff[1] <= req_bus.valid;
         end
         for (int k = 2; k <= STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_bus.ready = stage_en[1];
   assign in_acc        = req_bus.valid & req_bus.ready;
   assign out_acc       = rsp_bus.valid & rsp_bus.ready;

   // ---------------- shift amounts ----------------
   logic [W_BITS-1:0]   sh1;
   logic [SH2_BITS-1:0] sh2;

   assign sh1 = (modulus_bits_ff >= W_BITS'(BARRETT_OFS))
              ? modulus_bits_ff - W_BITS'(BARRETT_OFS) : '0;
   assign sh2 = SH2_BITS'(modulus_bits_ff) + SH2_BITS'(BARRETT_OFS);

   // ---------------- stage 1: modular sum and difference ----------------
   logic [SUM_BITS-1:0]         sum_raw, q_sum, sum_in;
   logic signed [DIFF_BITS-1:0] diff_raw, q_diff, diff_in;
   logic signed [DIFF_BITS-1:0] diff_ff;
   logic [VALUE_BITS-1:0]       tw_ff;
   logic [VALUE_BITS-1:0]       sum_pipe_ff [ST_SUM:STAGES];

   assign q_sum   = SUM_BITS'(modulus_ff);
   assign sum_raw = SUM_BITS'(req_bus.upper_value) + SUM_BITS'(req_bus.lower_value);
   assign sum_in  = (sum_raw >= q_sum) ? sum_raw - q_sum : sum_raw;

   assign q_diff   = $signed(DIFF_BITS'(modulus_ff));
   assign diff_raw = $signed(DIFF_BITS'(req_bus.upper_value)) + q_diff
                   - $signed(DIFF_BITS'(req_bus.lower_value));
   assign diff_in  = (diff_raw >= q_diff) ? diff_raw - q_diff : diff_raw;

   always_ff @(posedge clock) begin
      if (stage_en[ST_SUM]) begin
         sum_pipe_ff[ST_SUM] <= sum_in[VALUE_BITS-1:0];
         diff_ff             <= diff_in;
         tw_ff               <= req_bus.twiddle;
      end
      for (int k = ST_SUM + 1; k <= STAGES; k++) begin
         if (stage_en[k]) begin
            sum_pipe_ff[k] <= sum_pipe_ff[k-1];
         end
      end
   end

   // ---------------- stage 2: twiddle product ----------------
   logic signed [VALUE_BITS:0]   twx;
   logic signed [PROD_BITS-1:0]  tprod;
   logic signed [DP_BITS-1:0]    t_pipe_ff [ST_TW:ST_SQ];

   assign twx   = $signed({1'b0, tw_ff});
   assign tprod = diff_ff * twx;

   always_ff @(posedge clock) begin
      if (stage_en[ST_TW]) begin
         t_pipe_ff[ST_TW] <= {{(DP_BITS-PROD_BITS){tprod[PROD_BITS-1]}}, tprod};
      end
      for (int k = ST_TW + 1; k <= ST_SQ; k++) begin
         if (stage_en[k]) begin
            t_pipe_ff[k] <= t_pipe_ff[k-1];
         end
      end
   end

   // ---------------- stage 3: first Barrett shift ----------------
   logic [DP_BITS-1:0] x1_in, x1_ff;

   assign x1_in = t_pipe_ff[ST_TW] >>> sh1;

   always_ff @(posedge clock) begin
      if (stage_en[ST_SH1]) begin
         x1_ff <= x1_in;
      end
   end

   // ---------------- stages 4-5: x1 * u ----------------
   nbb_mul_ctl_type    mul_u_ctl;
   logic [DP_BITS-1:0] x2;

   assign mul_u_ctl.part_en = stage_en[ST_X2P];
   assign mul_u_ctl.sum_en  = stage_en[ST_X2];

   nbb_wrap_mul u_mul_u (
      .clock   (clock),
      .ctl     (mul_u_ctl),
      .a_op    (x1_ff),
      .b_op    (barrett_factor_ff),
      .product (x2)
   );

   // ---------------- stage 6: second Barrett shift ----------------
   logic [DP_BITS-1:0] s_in, s_ff;

   assign s_in = $signed(x2) >>> sh2;

   always_ff @(posedge clock) begin
      if (stage_en[ST_S]) begin
         s_ff <= s_in;
      end
   end

   // ---------------- stages 7-8: s * q ----------------
   nbb_mul_ctl_type    mul_q_ctl;
   logic [DP_BITS-1:0] sq;

   assign mul_q_ctl.part_en = stage_en[ST_SQP];
   assign mul_q_ctl.sum_en  = stage_en[ST_SQ];

   nbb_wrap_mul u_mul_q (
      .clock   (clock),
      .ctl     (mul_q_ctl),
      .a_op    (s_ff),
      .b_op    (U_BITS'(modulus_ff)),
      .product (sq)
   );

   // ---------------- stage 9: t - s*q ----------------
   logic [DP_BITS-1:0] c_in, c_ff;

   assign c_in = DP_BITS'(t_pipe_ff[ST_SQ]) - sq;

   always_ff @(posedge clock) begin
      if (stage_en[ST_C]) begin
         c_ff <= c_in;
      end
   end

   // ---------------- stage 10: final correction ----------------
   logic [DP_BITS-1:0]    q_wide, c_red;
   logic [VALUE_BITS-1:0] prod_out_ff;

   assign q_wide = DP_BITS'(modulus_ff);
   assign c_red  = ($signed(c_ff) >= $signed(q_wide)) ? c_ff - q_wide : c_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         prod_out_ff <= c_red[VALUE_BITS-1:0];
      end
   end

   assign rsp_bus.valid       = valid_ff[ST_OUT];
   assign rsp_bus.sum_out     = sum_pipe_ff[ST_OUT];
   assign rsp_bus.product_out = prod_out_ff;

   // ---------------- assertions ----------------
   `NBB_ASSERT_NEXT(a_word_count, clock, reset, 1'b1,
      $past(reset) || ($countones(valid_ff) == $past($countones(valid_ff))
      + int'($past(in_acc)) - int'($past(out_acc))))
   `NBB_ASSERT_IMPL(a_refuse_full, clock, reset, !req_bus.ready,
      (&valid_ff) && !rsp_bus.ready)
   `NBB_ASSERT_NEXT(a_sum_reduced, clock, reset,
      in_acc && (Q_BITS'(req_bus.upper_value) < modulus_ff)
      && (Q_BITS'(req_bus.lower_value) < modulus_ff),
      Q_BITS'(sum_pipe_ff[ST_SUM]) < $past(modulus_ff))
endmodule

/* sv/nbb_wrap_mul.sv */
// Two-stage 64 x 31 bit multiply, product kept modulo 2^64.
// Depends on nbb_pkg; stage enables come from the owner's pipeline control.
module nbb_wrap_mul (
   input  logic                          clock,
   input  nbb_pkg::nbb_mul_ctl_type      ctl,
   input  logic [nbb_pkg::DP_BITS-1:0]   a_op,
   input  logic [nbb_pkg::U_BITS-1:0]    b_op,
   output logic [nbb_pkg::DP_BITS-1:0]   product
);
   import nbb_pkg::*;

   localparam int LO_BITS = HALF_BITS + U_BITS;

   logic [LO_BITS-1:0]   lo_in, lo_ff;
   logic [HALF_BITS-1:0] hi_in, hi_ff;
   logic [DP_BITS-1:0]   prod_in, prod_ff;

   // high half only contributes its low 32 bits mod 2^64
   assign lo_in   = LO_BITS'(a_op[HALF_BITS-1:0]) * LO_BITS'(b_op);
   assign hi_in   = a_op[DP_BITS-1:HALF_BITS] * HALF_BITS'(b_op);
   assign prod_in = DP_BITS'(lo_ff) + {hi_ff, {HALF_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (ctl.part_en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (ctl.sum_en) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;
endmodule

/* tb/tb.sv */
// Self-checking bench for ntt_butterfly_barrett_core: streams butterfly words through the
// valid/ready channels across several modulus settings and checks each result word.
// Depends on nbb_pkg, nbb_req_if, nbb_rsp_if and the core RTL.
`timescale 1ns / 1ps

module tb;
   import nbb_pkg::*;

   localparam int VALUE_BITS   = 30;
   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 9;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 3 * STAGES;
   localparam int LIMIT_NS     = 2_000_000;

   localparam nbb_reg_index_type REG_UNUSED = 2'd3;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef struct packed {
      value_type sum_out;
      value_type product_out;
   } rsp_word_type;
   typedef enum {PRESSURE_NONE, PRESSURE_HOLD_RSP, PRESSURE_PAUSE_REQ} pressure_kind_type;

   localparam value_type ONES = '1;

   class butterfly_tracker;
      value_type         modulus;
      logic [W_BITS-1:0] modulus_bits;
      logic [U_BITS-1:0] barrett_factor;
      rsp_word_type      due_words[$];
      int                errors;

      function new();
         modulus        = MODULUS_RESET;
         modulus_bits   = MODULUS_BITS_RESET;
         barrett_factor = BARRETT_FACTOR_RESET;
         errors         = 0;
      endfunction

      function void set_reg(nbb_reg_index_type idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_MODULUS:        modulus = data[Q_BITS-1:0];
            REG_MODULUS_BITS:   modulus_bits = data[W_BITS-1:0];
            REG_BARRETT_FACTOR: barrett_factor = data[U_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_BITS-1:0] reg_value(nbb_reg_index_type idx);
         case (idx)
            REG_MODULUS:        return CSR_DATA_BITS'(modulus);
            REG_MODULUS_BITS:   return CSR_DATA_BITS'(modulus_bits);
            REG_BARRETT_FACTOR: return CSR_DATA_BITS'(barrett_factor);
            default:            return '0;
         endcase
      endfunction

      // 64-bit two's complement datapath, arithmetic shifts, signed final compare
      function rsp_word_type butterfly_of(value_type a, value_type b, value_type tw);
         longint       q_s, sum_s, diff_s, prod_s, x1, x2, quot, rem;
         int unsigned  sh1, sh2;
         rsp_word_type word;
         q_s = longint'(modulus);
         sum_s = longint'(a) + longint'(b);
         if (sum_s >= q_s) sum_s -= q_s;
         diff_s = longint'(a) + q_s - longint'(b);
         if (diff_s >= q_s) diff_s -= q_s;
         prod_s = diff_s * longint'(tw);
         sh1 = (modulus_bits >= 2) ? modulus_bits - 2 : 0;
         sh2 = modulus_bits + 2;
         x1 = prod_s >>> sh1;
         x2 = x1 * longint'(barrett_factor);
         quot = x2 >>> sh2;
         rem = prod_s - quot * q_s;
         if (rem >= q_s) rem -= q_s;
         word.sum_out = sum_s[VALUE_BITS-1:0];
         word.product_out = rem[VALUE_BITS-1:0];
         return word;
      endfunction

      function void note_word(value_type a, value_type b, value_type tw);
         due_words.push_back(butterfly_of(a, b, tw));
      endfunction

      function void flag(string what, logic [63:0] want, logic [63:0] got);
         errors++;
         if (errors <= 10)
            $display("%s: expected 0x%0h, got 0x%0h", what, want, got);
      endfunction

      function void check_word(value_type sum_v, value_type product_v);
         rsp_word_type want;
         if (due_words.size() == 0) begin
            flag("result word with none due", 0, {sum_v, product_v});
            return;
         end
         want = due_words.pop_front();
         if (want.sum_out !== sum_v) flag("sum_out", want.sum_out, sum_v);
         if (want.product_out !== product_v) flag("product_out", want.product_out, product_v);
      endfunction

      function int pending();
         return due_words.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   bit send_idle = 1'b0;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;

   butterfly_tracker tracker = new();

   nbb_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus();
   nbb_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_bus();

   ntt_butterfly_barrett_core #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   function automatic logic [U_BITS-1:0] barrett_of(value_type q, logic [W_BITS-1:0] w);
      return U_BITS'((64'd1 << (2 * w)) / q);
   endfunction

   function automatic value_type pick_operand(value_type q);
      int unsigned r;
      r = $urandom_range(0, 19);
      if (q == 0 || r < 3) return value_type'($urandom);
      if (r == 3) return '0;
      if (r == 4) return q - 1;
      return value_type'($urandom_range(0, q - 1));
   endfunction

   task automatic csr_transfer(input bit write, input nbb_reg_index_type idx,
                               input logic [CSR_DATA_BITS-1:0] data,
                               output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= CSR_ADDR_BITS'(idx) << CSR_IDX_LSB;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      if (write) tracker.set_reg(idx, data);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic verify_regs();
      logic [CSR_DATA_BITS-1:0] rd;
      for (int k = REG_MODULUS; k <= REG_BARRETT_FACTOR; k++) begin
         csr_transfer(1'b0, nbb_reg_index_type'(k), '0, rd);
         if (rd !== tracker.reg_value(nbb_reg_index_type'(k)))
            tracker.flag("register read", tracker.reg_value(nbb_reg_index_type'(k)), rd);
      end
   endtask

   task automatic send_word(value_type a, value_type b, value_type tw);
      req_bus.valid <= 1'b1;
      req_bus.upper_value <= a;
      req_bus.lower_value <= b;
      req_bus.twiddle <= tw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.note_word(a, b, tw);
      if (send_idle && !quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic run_phase(value_type q, logic [W_BITS-1:0] w, logic [U_BITS-1:0] u,
                            int count, pressure_kind_type pressure);
      logic [CSR_DATA_BITS-1:0] rd;
      csr_transfer(1'b1, REG_MODULUS, {2'($urandom), q}, rd);
      csr_transfer(1'b1, REG_MODULUS_BITS, {27'($urandom), w}, rd);
      csr_transfer(1'b1, REG_BARRETT_FACTOR, {1'($urandom), u}, rd);
      verify_regs();
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 0) send_idle = ($urandom_range(0, 2) != 0);
         if (i == count / 2 && pressure == PRESSURE_HOLD_RSP) hold_request = 1'b1;
         if (i == count / 2 && pressure == PRESSURE_PAUSE_REQ) drain();
         send_word(pick_operand(q), pick_operand(q), pick_operand(q));
      end
      drain();
   endtask

   // result side: random stall bursts, one long hold on request
   initial begin
      int stall_left;
      int mode_left;
      bit idle_mode;
      stall_left = 0;
      mode_left = 0;
      idle_mode = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            tracker.check_word(rsp_bus.sum_out, rsp_bus.product_out);
         if (mode_left == 0) begin
            idle_mode = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_mode && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [CSR_DATA_BITS-1:0] rd;
      value_type                q;
      logic [W_BITS-1:0]        w;
      req_bus.valid <= 1'b0;
      req_bus.upper_value <= '0;
      req_bus.lower_value <= '0;
      req_bus.twiddle <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      verify_regs();
      send_idle = 1'b1;
      q = MODULUS_RESET;
      send_word('0, '0, '0);
      send_word(q - 1, q - 1, q - 1);
      send_word('0, q - 1, q - 1);
      send_word(q - 1, '0, 1);
      send_word(777, 777, 4000);
      send_word(q, q, q);
      send_word(ONES, ONES, ONES);
      send_word('0, ONES, ONES);
      send_word(ONES, '0, ONES);
      send_word(1, 2, '0);
      send_word(q - 1, 1, 2);
      send_word(6000, 9000, 10000);
      drain();

      // write to the unmapped slot must leave the registers alone
      csr_transfer(1'b1, REG_UNUSED, $urandom, rd);

      run_phase(3329, 12, barrett_of(3329, 12), 50, PRESSURE_HOLD_RSP);
      run_phase(ONES, 30, barrett_of(ONES, 30), 50, PRESSURE_NONE);
      run_phase(2, 2, barrett_of(2, 2), 30, PRESSURE_NONE);
      run_phase(3, 1, barrett_of(3, 1), 30, PRESSURE_NONE);
      run_phase(5, 0, U_BITS'($urandom), 25, PRESSURE_NONE);
      run_phase(value_type'($urandom_range(2, 32'h3fff_ffff)), 31, '1, 30, PRESSURE_NONE);
      run_phase(8380417, 23, '0, 25, PRESSURE_PAUSE_REQ);
      for (int p = 0; p < 4; p++) begin
         w = W_BITS'($urandom_range(2, 30));
         q = value_type'($urandom_range((1 << w) - 1, 1 << (w - 1)));
         if (p == 3) quiet = 1'b1;
         run_phase(q, w, barrett_of(q, w), 50,
                   (p == 1) ? PRESSURE_PAUSE_REQ : PRESSURE_NONE);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("ntt_butterfly_barrett_core: match");
      end else begin
         $display("ntt_butterfly_barrett_core: mismatch");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("ntt_butterfly_barrett_core: mismatch");
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/nbb_pkg.sv
sv/nbb_req_if.sv
sv/nbb_rsp_if.sv
sv/nbb_wrap_mul.sv
sv/ntt_butterfly_barrett_core.sv
tb/tb.sv
